// ===== design/psf_pkg.sv =====
// psf_pkg: shared types and constants of the preamble/sync/length/checksum framer
// used by psf_emit and preamble_sync_length_checksum_framer; no dependencies
package psf_pkg;

  // number of preamble bytes ahead of the sync byte
  localparam int unsigned PREAMBLE_COUNT_DEF = 4;

  // configuration register indexes
  localparam logic [1:0] CFG_PREAMBLE = 2'd0;
  localparam logic [1:0] CFG_SYNC     = 2'd1;
  localparam logic [1:0] CFG_MAX_LEN  = 2'd2;

  // reset values of the configuration registers
  localparam logic [7:0] PREAMBLE_RST = 8'hAA;
  localparam logic [7:0] SYNC_RST     = 8'hD5;
  localparam logic [7:0] MAX_LEN_RST  = 8'hFF;

  // input opcodes
  localparam logic OP_START   = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  typedef enum logic [2:0] {
    KIND_PREAMBLE = 3'd0,
    KIND_SYNC     = 3'd1,
    KIND_LENGTH   = 3'd2,
    KIND_PAYLOAD  = 3'd3,
    KIND_CHECKSUM = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_TOO_LONG = 2'd1,
    ERR_NO_FRAME = 2'd2
  } err_e;

  // what one accepted item asks the emitter to send
  typedef enum logic [1:0] {
    JOB_START    = 2'd0,
    JOB_PAYLOAD  = 2'd1,
    JOB_TOO_LONG = 2'd2,
    JOB_NO_FRAME = 2'd3
  } job_e;

  typedef struct packed {
    job_e       op;
    logic       with_sum;  // a checksum closes this item's results
    logic [7:0] pre_byte;
    logic [7:0] sync_byte;
    logic [7:0] data_byte; // length byte on start, payload byte otherwise
    logic [7:0] sum_byte;
  } job_t;

endpackage

// ===== design/psf_emit.sv =====
// psf_emit: holds one decoded job and steps through its result bytes
// into the output register; depends on psf_pkg
module psf_emit import psf_pkg::*; #(
  parameter int unsigned PreambleCount = PREAMBLE_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  job_t       job_i,
  output logic       load_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] byte_kind_o,
  output logic [1:0] error_code_o,
  output logic       last_o
);

  localparam int unsigned IdxW = $clog2(PreambleCount + 3);
  localparam logic [IdxW-1:0] SyncIdx = IdxW'(PreambleCount);
  localparam logic [IdxW-1:0] LenIdx  = IdxW'(PreambleCount + 1);

  logic            job_v_q, job_v_d;
  job_t            job_q, job_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] last_idx;
  logic            take, fin;

  logic       out_v_q, out_v_d;
  logic [7:0] byte_q, byte_d;
  kind_e      kind_q, kind_d;
  err_e       err_q, err_d;
  logic       last_q, last_d;

  // index of the final result of the held job
  always_comb begin
    case (job_q.op)
      JOB_START:   last_idx = job_q.with_sum ? IdxW'(PreambleCount + 2) : LenIdx;
      JOB_PAYLOAD: last_idx = job_q.with_sum ? IdxW'(1) : '0;
      default:     last_idx = '0;
    endcase
  end

  // result fields for the current index
  always_comb begin
    byte_d = '0;
    kind_d = KIND_PREAMBLE;
    err_d  = ERR_NONE;
    case (job_q.op)
      JOB_START: begin
        if (idx_q < SyncIdx) begin
          byte_d = job_q.pre_byte;
          kind_d = KIND_PREAMBLE;
        end else if (idx_q == SyncIdx) begin
          byte_d = job_q.sync_byte;
          kind_d = KIND_SYNC;
        end else if (idx_q == LenIdx) begin
          byte_d = job_q.data_byte;
          kind_d = KIND_LENGTH;
        end else begin
          byte_d = job_q.sum_byte;
          kind_d = KIND_CHECKSUM;
        end
      end
      JOB_PAYLOAD: begin
        if (idx_q == '0) begin
          byte_d = job_q.data_byte;
          kind_d = KIND_PAYLOAD;
        end else begin
          byte_d = job_q.sum_byte;
          kind_d = KIND_CHECKSUM;
        end
      end
      JOB_TOO_LONG: err_d = ERR_TOO_LONG;
      default:      err_d = ERR_NO_FRAME;
    endcase
    last_d = (idx_q == last_idx);
  end

  // one result moves per cycle when the output register is free
  assign take         = job_v_q && (!out_v_q || out_ready_i);
  assign fin          = take && last_d;
  assign load_ready_o = !job_v_q || fin;

  // job slot and result index
  always_comb begin
    job_v_d = job_v_q;
    job_d   = job_q;
    idx_d   = idx_q;
    if (load_i) begin
      job_v_d = 1'b1;
      job_d   = job_i;
      idx_d   = '0;
    end else if (fin) begin
      job_v_d = 1'b0;
    end else if (take) begin
      idx_d = idx_q + IdxW'(1);
    end
  end

  // output register valid
  always_comb begin
    out_v_d = out_v_q;
    if (take) begin
      out_v_d = 1'b1;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_v_q <= 1'b0;
      idx_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      job_v_q <= job_v_d;
      idx_q   <= idx_d;
      out_v_q <= out_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (take) begin
      byte_q <= byte_d;
      kind_q <= kind_d;
      err_q  <= err_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o  = out_v_q;
  assign out_byte_o   = byte_q;
  assign byte_kind_o  = kind_q;
  assign error_code_o = err_q;
  assign last_o       = last_q;

endmodule

// ===== design/preamble_sync_length_checksum_framer.sv =====
// preamble_sync_length_checksum_framer: top level of the byte framer
// holds configuration and frame state; instantiates psf_emit; depends on psf_pkg
//
// Usage: an input transfer carries opcode_i (0 start, 1 payload byte),
// frame_length_i and data_byte_i. A start within max_length yields
// PreambleCount preamble bytes, the sync byte and the length byte, plus a
// checksum when the length is zero; an over-long start yields one error
// result. A payload byte yields the byte, plus the checksum after the final
// one; a payload byte with no open frame yields one error result. Each
// output transfer carries one byte, its kind, an error code and last, which
// marks the final result of an input item.
// An item's first result is held in the emitter's job slot and then
// registered in the output register. The emitter sends one result per
// cycle while the output register is free; an item has 1 or 2 results
// for payload bytes, PreambleCount+2 or +3 for starts. The next item is
// taken in the cycle its predecessor's last result is registered.
// Reset clears the frame state, the output and restores register defaults.
// When the receiver stalls, the output register holds, one item waits in
// the emitter, and in_ready_o drops until the emitter drains.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) are registered
// and apply to items accepted after the write; index 3 is ignored.
module preamble_sync_length_checksum_framer import psf_pkg::*; #(
  parameter int unsigned PreambleCount = PREAMBLE_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       opcode_i,
  input  logic [7:0] frame_length_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [2:0] byte_kind_o,
  output logic [1:0] error_code_o,
  output logic       last_o
);

  logic [7:0] pre_q, sync_q, max_len_q;
  logic       open_q, open_d;
  logic [7:0] rem_q, rem_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] sum_add, rem_dec;
  logic       accept;
  job_t       job;

  assign accept  = in_valid_i && in_ready_o;
  assign sum_add = sum_q + data_byte_i;
  assign rem_dec = rem_q - 8'd1;

  // decode the item and update frame state
  always_comb begin
    open_d        = open_q;
    rem_d         = rem_q;
    sum_d         = sum_q;
    job.op        = JOB_NO_FRAME;
    job.with_sum  = 1'b0;
    job.pre_byte  = pre_q;
    job.sync_byte = sync_q;
    job.data_byte = data_byte_i;
    job.sum_byte  = '0;
    if (opcode_i == OP_START) begin
      open_d        = 1'b0;
      rem_d         = '0;
      job.data_byte = frame_length_i;
      if (frame_length_i > max_len_q) begin
        sum_d  = '0;
        job.op = JOB_TOO_LONG;
      end else if (frame_length_i == '0) begin
        sum_d        = '0;
        job.op       = JOB_START;
        job.with_sum = 1'b1;
      end else begin
        open_d = 1'b1;
        rem_d  = frame_length_i;
        sum_d  = frame_length_i;
        job.op = JOB_START;
      end
    end else if (open_q && (rem_q != '0)) begin
      job.op = JOB_PAYLOAD;
      if (rem_dec == '0) begin
        job.with_sum = 1'b1;
        job.sum_byte = sum_add;
        open_d       = 1'b0;
        rem_d        = '0;
        sum_d        = '0;
      end else begin
        rem_d = rem_dec;
        sum_d = sum_add;
      end
    end
  end

  // configuration registers and frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_q     <= PREAMBLE_RST;
      sync_q    <= SYNC_RST;
      max_len_q <= MAX_LEN_RST;
      open_q    <= 1'b0;
      rem_q     <= '0;
      sum_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_PREAMBLE: pre_q     <= cfg_data_i;
          CFG_SYNC:     sync_q    <= cfg_data_i;
          CFG_MAX_LEN:  max_len_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        open_q <= open_d;
        rem_q  <= rem_d;
        sum_q  <= sum_d;
      end
    end
  end

  psf_emit #(
    .PreambleCount(PreambleCount)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .job_i        (job),
    .load_ready_o (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .byte_kind_o  (byte_kind_o),
    .error_code_o (error_code_o),
    .last_o       (last_o)
  );

endmodule
